// ===== hdl/hrhp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request head parser package
// Phase type, event, role and error codes, and the method and version tables.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	typedef enum logic [3:0] {
		PH_METHOD,
		PH_URI_FIRST,
		PH_URI,
		PH_VERSION,
		PH_VERSION_LF,
		PH_LINE_START,
		PH_NAME,
		PH_VALUE_LEAD,
		PH_VALUE,
		PH_LINE_LF,
		PH_END_LF,
		PH_DONE,
		PH_ERROR
	} phase_t;

	localparam logic [2:0] EV_NONE        = 3'd0;
	localparam logic [2:0] EV_REQUEST_LINE = 3'd1;
	localparam logic [2:0] EV_HEADER_LINE = 3'd2;
	localparam logic [2:0] EV_HEAD_DONE   = 3'd3;
	localparam logic [2:0] EV_ERROR       = 3'd4;

	localparam logic [2:0] ROLE_NONE    = 3'd0;
	localparam logic [2:0] ROLE_METHOD  = 3'd1;
	localparam logic [2:0] ROLE_URI     = 3'd2;
	localparam logic [2:0] ROLE_VERSION = 3'd3;
	localparam logic [2:0] ROLE_NAME    = 3'd4;
	localparam logic [2:0] ROLE_VALUE   = 3'd5;

	localparam logic [3:0] ERR_NONE          = 4'd0;
	localparam logic [3:0] ERR_BAD_METHOD    = 4'd1;
	localparam logic [3:0] ERR_NO_SLASH      = 4'd2;
	localparam logic [3:0] ERR_URI_LONG      = 4'd3;
	localparam logic [3:0] ERR_DOT_DOT       = 4'd4;
	localparam logic [3:0] ERR_BAD_VERSION   = 4'd5;
	localparam logic [3:0] ERR_METHOD_10     = 4'd6;
	localparam logic [3:0] ERR_MANY_HEADERS  = 4'd7;
	localparam logic [3:0] ERR_MALFORMED     = 4'd8;
	localparam logic [3:0] ERR_HEADER_LONG   = 4'd9;

	localparam logic [1:0] CFG_MAX_URI          = 2'd0;
	localparam logic [1:0] CFG_MAX_HEADER_LINES = 2'd1;
	localparam logic [1:0] CFG_MAX_HEADER_LEN   = 2'd2;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SP    = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ONE   = 8'h31;

	localparam int NUM_METHODS = 9;
	// Highest method code that HTTP/1.0 allows.
	localparam logic [3:0] METHOD_MAX_V10 = 4'd2;

	localparam logic [7:0] METHOD_CHARS [NUM_METHODS][8] = '{
		'{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
		'{"C", "O", "N", "N", "E", "C", "T", 8'h00},
		'{"O", "P", "T", "I", "O", "N", "S", 8'h00},
		'{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
		'{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] METHOD_LENGTHS [NUM_METHODS] = '{
		4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5
	};

	localparam logic [7:0] VERSION_PREFIX [8] = '{
		"H", "T", "T", "P", "/", "1", ".", 8'h00
	};

endpackage
`default_nettype wire

// ===== hdl/http_request_head_parser_top.sv =====
`default_nettype none
// Each result passes the input register and then the result register before it is valid.
// One byte per cycle while results are taken; the parse state advances once per accepted byte.
// A result waiting in the output register still lets one more byte into the input register;
// further bytes wait until the result is taken.
// Reset is asynchronous and active low: it clears the parse state, the stage valid flags,
// and loads the limits with their defaults (2048, 64, 8192).
// ----------------------------------------------------------------------------
// HTTP request head parser
// Byte-serial parser of an HTTP/1.x request line and header lines with limit checks.
// ----------------------------------------------------------------------------
module http_request_head_parser_top
	import hrhp_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        new_request,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       event_res,
	output logic [2:0]       byte_role,
	output logic [3:0]       method_code,
	output logic             version_code,
	output logic [15:0]      uri_length,
	output logic [7:0]       header_total,
	output logic [15:0]      name_length,
	output logic [15:0]      value_length,
	output logic [3:0]       error_code,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int CMP_W = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

	typedef logic [LENGTH_BITS-1:0] len_t;

	function automatic len_t bump(input len_t v);
		return (&v) ? v : v + len_t'(1);
	endfunction

	// Configuration.
	logic [15:0] max_uri_q;
	logic [7:0]  max_lines_q;
	logic [15:0] max_hdr_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_uri_q     <= 16'd2048;
			max_lines_q   <= 8'd64;
			max_hdr_len_q <= 16'd8192;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_URI:          max_uri_q     <= cfg_data;
				CFG_MAX_HEADER_LINES: max_lines_q   <= cfg_data[7:0];
				CFG_MAX_HEADER_LEN:   max_hdr_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       new_req_s1;
	logic       valid_s2;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1    <= data_byte;
			new_req_s1 <= new_request;
		end
	end

	// Parse state.
	phase_t          phase_q;
	logic [8:0]      cand_q;
	logic [3:0]      mpos_q;
	logic [3:0]      mseen_q;
	logic            vseen_q;
	len_t            uri_q;
	logic            pdot_q;
	logic [7:0]      hcount_q;
	len_t            ncount_q;
	len_t            vcount_q;

	// State as seen by the current byte, after an optional restart.
	phase_t          ph;
	logic [8:0]      cand;
	logic [3:0]      mpos;
	logic [3:0]      mseen;
	logic            vseen;
	len_t            uri;
	logic            pdot;
	logic [7:0]      hcount;
	len_t            ncount;
	len_t            vcount;

	assign ph     = new_req_s1 ? PH_METHOD : phase_q;
	assign cand   = new_req_s1 ? '1 : cand_q;
	assign mpos   = new_req_s1 ? 4'd0 : mpos_q;
	assign mseen  = new_req_s1 ? 4'd0 : mseen_q;
	assign vseen  = new_req_s1 ? 1'b0 : vseen_q;
	assign uri    = new_req_s1 ? '0 : uri_q;
	assign pdot   = new_req_s1 ? 1'b0 : pdot_q;
	assign hcount = new_req_s1 ? 8'd0 : hcount_q;
	assign ncount = new_req_s1 ? '0 : ncount_q;
	assign vcount = new_req_s1 ? '0 : vcount_q;

	// Method matching against all names in parallel.
	logic [8:0] keep;
	logic [8:0] len_hit;
	logic [8:0] cand_next;
	logic [3:0] hit_index;

	always_comb begin
		hit_index = 4'd0;
		for (int i = 0; i < NUM_METHODS; i++) begin
			keep[i]    = (mpos < METHOD_LENGTHS[i]) && (METHOD_CHARS[i][mpos[2:0]] == byte_s1);
			len_hit[i] = cand[i] && (METHOD_LENGTHS[i] == mpos);
		end
		for (int i = NUM_METHODS - 1; i >= 0; i--) begin
			if (len_hit[i]) begin
				hit_index = 4'(i);
			end
		end
		cand_next = cand & keep;
	end

	// Length checks.
	len_t uri_inc;
	logic uri_over;
	len_t name_inc;
	len_t value_inc;
	logic name_over;
	logic value_over;
	len_t name_base;
	len_t value_base;

	assign uri_inc    = bump(uri);
	assign uri_over   = CMP_W'(uri_inc) > CMP_W'(max_uri_q);
	// The first name byte of a line starts from cleared counters.
	assign name_base  = (ph == PH_LINE_START) ? '0 : ncount;
	assign value_base = (ph == PH_LINE_START) ? '0 : vcount;
	assign name_inc   = bump(name_base);
	assign value_inc  = bump(vcount);
	assign name_over  = (CMP_W'(name_inc) + CMP_W'(value_base)) > CMP_W'(max_hdr_len_q);
	assign value_over = (CMP_W'(ncount) + CMP_W'(value_inc)) > CMP_W'(max_hdr_len_q);

	logic is_cr;
	logic is_lf;
	logic is_sp;

	assign is_cr = (byte_s1 == CHAR_CR);
	assign is_lf = (byte_s1 == CHAR_LF);
	assign is_sp = (byte_s1 == CHAR_SP);

	// Next phase and error code.
	phase_t     phase_d;
	logic [3:0] err_d;

	always_comb begin
		phase_d = ph;
		err_d   = ERR_NONE;
		unique case (ph)
			PH_METHOD: begin
				if (is_sp) begin
					if (|len_hit) begin
						phase_d = PH_URI_FIRST;
					end else begin
						err_d = ERR_BAD_METHOD;
					end
				end else if (cand_next == '0) begin
					err_d = ERR_BAD_METHOD;
				end
			end
			PH_URI_FIRST: begin
				if (byte_s1 != CHAR_SLASH) begin
					err_d = ERR_NO_SLASH;
				end else if (uri_over) begin
					err_d = ERR_URI_LONG;
				end else begin
					phase_d = PH_URI;
				end
			end
			PH_URI: begin
				if (is_sp) begin
					phase_d = PH_VERSION;
				end else if (is_cr || is_lf) begin
					err_d = ERR_BAD_VERSION;
				end else if (uri_over) begin
					err_d = ERR_URI_LONG;
				end else if (byte_s1 == CHAR_DOT && pdot) begin
					err_d = ERR_DOT_DOT;
				end
			end
			PH_VERSION: begin
				if (mpos < 4'd7) begin
					if (VERSION_PREFIX[mpos[2:0]] != byte_s1) begin
						err_d = ERR_BAD_VERSION;
					end
				end else if (mpos == 4'd7) begin
					if (byte_s1 != CHAR_ZERO && byte_s1 != CHAR_ONE) begin
						err_d = ERR_BAD_VERSION;
					end
				end else if (!is_cr) begin
					err_d = ERR_BAD_VERSION;
				end else if (!vseen && mseen > METHOD_MAX_V10) begin
					err_d = ERR_METHOD_10;
				end else begin
					phase_d = PH_VERSION_LF;
				end
			end
			PH_VERSION_LF: begin
				if (is_lf) begin
					phase_d = PH_LINE_START;
				end else begin
					err_d = ERR_BAD_VERSION;
				end
			end
			PH_LINE_START: begin
				if (is_cr) begin
					phase_d = PH_END_LF;
				end else if (hcount >= max_lines_q) begin
					err_d = ERR_MANY_HEADERS;
				end else if (byte_s1 == CHAR_COLON || is_lf) begin
					err_d = ERR_MALFORMED;
				end else if (name_over) begin
					err_d = ERR_HEADER_LONG;
				end else begin
					phase_d = PH_NAME;
				end
			end
			PH_NAME: begin
				if (byte_s1 == CHAR_COLON) begin
					phase_d = PH_VALUE_LEAD;
				end else if (is_cr || is_lf) begin
					err_d = ERR_MALFORMED;
				end else if (name_over) begin
					err_d = ERR_HEADER_LONG;
				end
			end
			PH_VALUE_LEAD, PH_VALUE: begin
				if (is_cr) begin
					phase_d = PH_LINE_LF;
				end else if (is_lf) begin
					err_d = ERR_MALFORMED;
				end else if (ph == PH_VALUE_LEAD && (is_sp || byte_s1 == CHAR_TAB)) begin
					phase_d = PH_VALUE_LEAD;
				end else if (value_over) begin
					err_d = ERR_HEADER_LONG;
				end else begin
					phase_d = PH_VALUE;
				end
			end
			PH_LINE_LF: begin
				if (is_lf) begin
					phase_d = PH_LINE_START;
				end else begin
					err_d = ERR_MALFORMED;
				end
			end
			PH_END_LF: begin
				if (is_lf) begin
					phase_d = PH_DONE;
				end else begin
					err_d = ERR_MALFORMED;
				end
			end
			PH_DONE, PH_ERROR: begin
				phase_d = ph;
			end
			default: begin
				phase_d = PH_ERROR;
			end
		endcase
		if (err_d != ERR_NONE) begin
			phase_d = PH_ERROR;
		end
	end

	// Result fields and datapath updates.
	logic [2:0] ev_d;
	logic [2:0] role_d;
	logic [8:0] cand_d;
	logic [3:0] mpos_d;
	logic [3:0] mseen_d;
	logic       vseen_d;
	len_t       uri_d;
	logic       pdot_d;
	logic [7:0] hcount_d;
	len_t       ncount_d;
	len_t       vcount_d;

	always_comb begin
		ev_d     = EV_NONE;
		role_d   = ROLE_NONE;
		cand_d   = cand;
		mpos_d   = mpos;
		mseen_d  = mseen;
		vseen_d  = vseen;
		uri_d    = uri;
		pdot_d   = pdot;
		hcount_d = hcount;
		ncount_d = ncount;
		vcount_d = vcount;
		unique case (ph)
			PH_METHOD: begin
				if (is_sp) begin
					if (|len_hit) begin
						mseen_d = hit_index;
					end
				end else begin
					cand_d = cand_next;
					if (mpos < 4'd15) begin
						mpos_d = mpos + 4'd1;
					end
					role_d = ROLE_METHOD;
				end
			end
			PH_URI_FIRST: begin
				if (byte_s1 == CHAR_SLASH) begin
					uri_d  = uri_inc;
					pdot_d = 1'b0;
					role_d = ROLE_URI;
				end
			end
			PH_URI: begin
				if (is_sp) begin
					mpos_d = 4'd0;
				end else if (!is_cr && !is_lf) begin
					uri_d  = uri_inc;
					pdot_d = (byte_s1 == CHAR_DOT);
					role_d = ROLE_URI;
				end
			end
			PH_VERSION: begin
				if (mpos < 4'd7) begin
					mpos_d = mpos + 4'd1;
					role_d = ROLE_VERSION;
				end else if (mpos == 4'd7) begin
					if (byte_s1 == CHAR_ZERO || byte_s1 == CHAR_ONE) begin
						vseen_d = (byte_s1 == CHAR_ONE);
					end
					mpos_d = 4'd8;
					role_d = ROLE_VERSION;
				end
			end
			PH_VERSION_LF: begin
				ev_d = EV_REQUEST_LINE;
			end
			PH_LINE_START: begin
				if (!is_cr && hcount < max_lines_q && byte_s1 != CHAR_COLON && !is_lf) begin
					ncount_d = name_inc;
					vcount_d = '0;
					role_d   = ROLE_NAME;
				end
			end
			PH_NAME: begin
				if (byte_s1 != CHAR_COLON && !is_cr && !is_lf) begin
					ncount_d = name_inc;
					role_d   = ROLE_NAME;
				end
			end
			PH_VALUE_LEAD, PH_VALUE: begin
				if (!is_cr && !is_lf &&
				    !(ph == PH_VALUE_LEAD && (is_sp || byte_s1 == CHAR_TAB))) begin
					vcount_d = value_inc;
					role_d   = ROLE_VALUE;
				end
			end
			PH_LINE_LF: begin
				if (is_lf) begin
					if (hcount != 8'hFF) begin
						hcount_d = hcount + 8'd1;
					end
					ev_d = EV_HEADER_LINE;
				end
			end
			PH_END_LF: begin
				ev_d = EV_HEAD_DONE;
			end
			PH_DONE, PH_ERROR: begin
				ev_d = EV_NONE;
			end
			default: begin
				ev_d = EV_NONE;
			end
		endcase
		if (err_d != ERR_NONE) begin
			ev_d   = EV_ERROR;
			role_d = ROLE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_METHOD;
			cand_q   <= '1;
			mpos_q   <= 4'd0;
			mseen_q  <= 4'd0;
			vseen_q  <= 1'b0;
			uri_q    <= '0;
			pdot_q   <= 1'b0;
			hcount_q <= 8'd0;
			ncount_q <= '0;
			vcount_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			cand_q   <= cand_d;
			mpos_q   <= mpos_d;
			mseen_q  <= mseen_d;
			vseen_q  <= vseen_d;
			uri_q    <= uri_d;
			pdot_q   <= pdot_d;
			hcount_q <= hcount_d;
			ncount_q <= ncount_d;
			vcount_q <= vcount_d;
		end
	end

	// Result register.
	logic [2:0]  event_s2;
	logic [2:0]  role_s2;
	logic [3:0]  method_s2;
	logic        version_s2;
	logic [15:0] uri_s2;
	logic [7:0]  hcount_s2;
	logic [15:0] name_s2;
	logic [15:0] value_s2;
	logic [3:0]  err_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2   <= ev_d;
			role_s2    <= role_d;
			method_s2  <= mseen_d;
			version_s2 <= vseen_d;
			uri_s2     <= 16'(uri_d);
			hcount_s2  <= hcount_d;
			name_s2    <= 16'(ncount_d);
			value_s2   <= 16'(vcount_d);
			err_s2     <= err_d;
		end
	end

	assign out_valid    = valid_s2;
	assign event_res    = event_s2;
	assign byte_role    = role_s2;
	assign method_code  = method_s2;
	assign version_code = version_s2;
	assign uri_length   = uri_s2;
	assign header_total = hcount_s2;
	assign name_length  = name_s2;
	assign value_length = value_s2;
	assign error_code   = err_s2;

	// An error code travels only with the error event.
	a_err_with_event: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((err_s2 != ERR_NONE) == (event_s2 == EV_ERROR)))
		else $error("error code and error event disagree");

	// A byte that carries a role never raises an event.
	a_role_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && role_s2 != ROLE_NONE) |-> (event_s2 == EV_NONE))
		else $error("byte with a role reported an event");

	// Once failed, the parser stays failed until a new request.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !new_req_s1 && phase_q == PH_ERROR) |=> (phase_q == PH_ERROR))
		else $error("parser left the error phase without a new request");

	// An empty input register always takes a byte.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while input register empty");

	// A result that is not taken stays in place.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(event_s2) && $stable(err_s2)))
		else $error("pending result changed before it was taken");

endmodule
`default_nettype wire

// ===== sim/http_request_head_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// HTTP request head parser testbench
// Feeds request heads one byte per transaction through the valid/ready input,
// predicts every result with a behavioral model of the parser, and compares
// the results field by field. A short scripted opening covers byte extremes,
// bad methods and the 1.0 method rule. Random requests follow, under several
// limit settings that include the smallest and largest values.
// ----------------------------------------------------------------------------
module http_request_head_parser_top_tb;
	import hrhp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LAP_BYTES = 200;
	localparam int LAPS = 8;

	localparam int FILL_URI = 0;
	localparam int FILL_NAME = 1;
	localparam int FILL_VALUE = 2;
	localparam int FILL_ODD = 3;

	localparam logic [55:0] VERB_TEXT [9] = '{
		"GET", "HEAD", "POST", "PUT", "DELETE", "CONNECT", "OPTIONS", "TRACE", "PATCH"
	};
	localparam int VERB_LEN [9] = '{3, 4, 4, 3, 6, 7, 7, 5, 5};
	localparam logic [55:0] VERSION_HEAD = "HTTP/1.";

	typedef struct packed {
		logic [2:0]  ev;
		logic [2:0]  role;
		logic [3:0]  meth;
		logic        ver;
		logic [15:0] uri;
		logic [7:0]  hdrs;
		logic [15:0] name_len;
		logic [15:0] value_len;
		logic [3:0]  err;
	} head_res_t;

	// One byte of stimulus; when typed is set, ev, role and err are the expected values.
	typedef struct packed {
		logic [7:0] b;
		logic       nr;
		logic       typed;
		logic [2:0] ev;
		logic [2:0] role;
		logic [3:0] err;
	} byte_row_t;

	localparam int OPENING_ROWS = 24;
	localparam byte_row_t OPENING [OPENING_ROWS] = '{
		'{8'h58, 1'b1, 1'b1, EV_ERROR, ROLE_NONE, ERR_BAD_METHOD},
		'{8'hFF, 1'b0, 1'b1, EV_NONE, ROLE_NONE, ERR_NONE},
		'{8'h00, 1'b1, 1'b1, EV_ERROR, ROLE_NONE, ERR_BAD_METHOD},
		'{CHAR_SP, 1'b1, 1'b1, EV_ERROR, ROLE_NONE, ERR_BAD_METHOD},
		'{CHAR_CR, 1'b1, 1'b1, EV_ERROR, ROLE_NONE, ERR_BAD_METHOD},
		'{"P", 1'b1, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{"U", 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{"T", 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{CHAR_SP, 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{CHAR_SLASH, 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{CHAR_SP, 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{"H", 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{"T", 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{"T", 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{"P", 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{CHAR_SLASH, 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{CHAR_ONE, 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{CHAR_DOT, 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{CHAR_ZERO, 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{CHAR_CR, 1'b0, 1'b1, EV_ERROR, ROLE_NONE, ERR_METHOD_10},
		'{"D", 1'b1, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{"E", 1'b0, 1'b0, EV_NONE, ROLE_NONE, ERR_NONE},
		'{CHAR_SP, 1'b0, 1'b1, EV_ERROR, ROLE_NONE, ERR_BAD_METHOD},
		'{8'hFF, 1'b1, 1'b1, EV_ERROR, ROLE_NONE, ERR_BAD_METHOD}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        new_request = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_res;
	logic [2:0]  byte_role;
	logic [3:0]  method_code;
	logic        version_code;
	logic [15:0] uri_length;
	logic [7:0]  header_total;
	logic [15:0] name_length;
	logic [15:0] value_length;
	logic [3:0]  error_code;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_MAX_URI;
	logic [15:0] cfg_data = 16'h0000;

	// Parser state as predicted by the testbench.
	phase_t      st_phase;
	logic [8:0]  st_cand;
	logic [3:0]  st_pos;
	logic [3:0]  st_method;
	logic        st_version;
	logic [15:0] st_uri;
	logic        st_dot;
	logic [7:0]  st_lines;
	logic [15:0] st_name;
	logic [15:0] st_value;

	logic [15:0] lim_uri = 16'd2048;
	logic [7:0]  lim_lines = 8'd64;
	logic [15:0] lim_hdr = 16'd8192;

	head_res_t parse_results_due[$];
	int fails = 0;
	int sent_bytes = 0;
	int send_calm = 0;
	int recv_calm = 0;

	http_request_head_parser_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.new_request  (new_request),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.byte_role    (byte_role),
		.method_code  (method_code),
		.version_code (version_code),
		.uri_length   (uri_length),
		.header_total (header_total),
		.name_length  (name_length),
		.value_length (value_length),
		.error_code   (error_code),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] verb_char(input int m, input int p);
		if (p >= VERB_LEN[m])
			return 8'h00;
		return VERB_TEXT[m][8*(VERB_LEN[m]-1-p) +: 8];
	endfunction

	function automatic logic [15:0] step_count(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic void clear_parse();
		st_phase = PH_METHOD;
		st_cand = '1;
		st_pos = '0;
		st_method = '0;
		st_version = 1'b0;
		st_uri = '0;
		st_dot = 1'b0;
		st_lines = '0;
		st_name = '0;
		st_value = '0;
	endfunction

	function automatic head_res_t parse_byte(input logic [7:0] b, input logic nr);
		head_res_t r;
		logic [3:0] code;
		logic matched;
		logic do_uri;
		logic do_name;
		logic do_value;
		logic [16:0] both;
		int i;
		int p;
		if (nr)
			clear_parse();
		r = '0;
		code = ERR_NONE;
		do_uri = 1'b0;
		do_name = 1'b0;
		do_value = 1'b0;
		p = int'(st_pos);
		case (st_phase)
			PH_METHOD: begin
				if (b == CHAR_SP) begin
					matched = 1'b0;
					for (i = 0; i < 9; i++) begin
						if (!matched && st_cand[i] && VERB_LEN[i] == p) begin
							st_method = i[3:0];
							st_phase = PH_URI_FIRST;
							matched = 1'b1;
						end
					end
					if (!matched)
						code = ERR_BAD_METHOD;
				end else begin
					for (i = 0; i < 9; i++)
						if (!(p < VERB_LEN[i] && verb_char(i, p) == b))
							st_cand[i] = 1'b0;
					if (st_cand == '0) begin
						code = ERR_BAD_METHOD;
					end else begin
						if (st_pos < 4'd15)
							st_pos = st_pos + 4'd1;
						r.role = ROLE_METHOD;
					end
				end
			end
			PH_URI_FIRST: begin
				if (b != CHAR_SLASH) begin
					code = ERR_NO_SLASH;
				end else begin
					st_phase = PH_URI;
					do_uri = 1'b1;
				end
			end
			PH_URI: begin
				if (b == CHAR_SP) begin
					st_phase = PH_VERSION;
					st_pos = '0;
				end else if (b == CHAR_CR || b == CHAR_LF) begin
					code = ERR_BAD_VERSION;
				end else begin
					do_uri = 1'b1;
				end
			end
			PH_VERSION: begin
				if (p < 7) begin
					if (VERSION_HEAD[8*(6-p) +: 8] != b) begin
						code = ERR_BAD_VERSION;
					end else begin
						st_pos = st_pos + 4'd1;
						r.role = ROLE_VERSION;
					end
				end else if (p == 7) begin
					if (b != CHAR_ZERO && b != CHAR_ONE) begin
						code = ERR_BAD_VERSION;
					end else begin
						st_version = (b == CHAR_ONE);
						st_pos = 4'd8;
						r.role = ROLE_VERSION;
					end
				end else if (b != CHAR_CR) begin
					code = ERR_BAD_VERSION;
				end else if (!st_version && st_method > METHOD_MAX_V10) begin
					code = ERR_METHOD_10;
				end else begin
					st_phase = PH_VERSION_LF;
				end
			end
			PH_VERSION_LF: begin
				if (b != CHAR_LF) begin
					code = ERR_BAD_VERSION;
				end else begin
					r.ev = EV_REQUEST_LINE;
					st_phase = PH_LINE_START;
				end
			end
			PH_LINE_START: begin
				if (b == CHAR_CR) begin
					st_phase = PH_END_LF;
				end else if (st_lines >= lim_lines) begin
					code = ERR_MANY_HEADERS;
				end else if (b == CHAR_COLON || b == CHAR_LF) begin
					code = ERR_MALFORMED;
				end else begin
					st_name = '0;
					st_value = '0;
					do_name = 1'b1;
				end
			end
			PH_NAME: begin
				if (b == CHAR_COLON)
					st_phase = PH_VALUE_LEAD;
				else if (b == CHAR_CR || b == CHAR_LF)
					code = ERR_MALFORMED;
				else
					do_name = 1'b1;
			end
			PH_VALUE_LEAD, PH_VALUE: begin
				if (b == CHAR_CR)
					st_phase = PH_LINE_LF;
				else if (b == CHAR_LF)
					code = ERR_MALFORMED;
				else if (st_phase == PH_VALUE_LEAD && (b == CHAR_SP || b == CHAR_TAB))
					r.role = ROLE_NONE;
				else
					do_value = 1'b1;
			end
			PH_LINE_LF: begin
				if (b != CHAR_LF) begin
					code = ERR_MALFORMED;
				end else begin
					if (st_lines != 8'hFF)
						st_lines = st_lines + 8'd1;
					r.ev = EV_HEADER_LINE;
					st_phase = PH_LINE_START;
				end
			end
			PH_END_LF: begin
				if (b != CHAR_LF) begin
					code = ERR_MALFORMED;
				end else begin
					r.ev = EV_HEAD_DONE;
					st_phase = PH_DONE;
				end
			end
			default: ;
		endcase

		// The length limit on the target is checked before the dot-dot rule.
		if (do_uri) begin
			st_uri = step_count(st_uri);
			if (st_uri > lim_uri) begin
				code = ERR_URI_LONG;
			end else if (b == CHAR_DOT && st_dot) begin
				code = ERR_DOT_DOT;
			end else begin
				st_dot = (b == CHAR_DOT);
				r.role = ROLE_URI;
			end
		end
		if (do_name)
			st_name = step_count(st_name);
		if (do_value)
			st_value = step_count(st_value);
		if (do_name || do_value) begin
			both = {1'b0, st_name} + {1'b0, st_value};
			if (both > {1'b0, lim_hdr}) begin
				code = ERR_HEADER_LONG;
			end else begin
				r.role = do_name ? ROLE_NAME : ROLE_VALUE;
				st_phase = do_name ? PH_NAME : PH_VALUE;
			end
		end

		if (code != ERR_NONE) begin
			st_phase = PH_ERROR;
			r.ev = EV_ERROR;
			r.role = ROLE_NONE;
			r.err = code;
		end
		r.meth = st_method;
		r.ver = st_version;
		r.uri = st_uri;
		r.hdrs = st_lines;
		r.name_len = st_name;
		r.value_len = st_value;
		return r;
	endfunction

	function automatic int pick_wait(inout int calm);
		int w;
		if (calm > 0) begin
			calm = calm - 1;
			w = 0;
		end else begin
			w = $urandom_range(0, 3);
			if ($urandom_range(0, 31) == 0)
				calm = $urandom_range(8, 40);
		end
		return w;
	endfunction

	function automatic logic [7:0] filler(input int kind);
		int k;
		logic [7:0] c;
		k = $urandom_range(0, 15);
		c = 8'($urandom_range(0, 255));
		if (k == 0)
			return c;
		c = 8'h61 + 8'($urandom_range(0, 25));
		case (kind)
			FILL_URI: begin
				if (k < 3)
					c = CHAR_DOT;
				else if (k < 5)
					c = CHAR_SLASH;
			end
			FILL_NAME: begin
				if (k < 3)
					c = "-";
				else if (k < 6)
					c = c - 8'h20;
			end
			FILL_VALUE: begin
				if (k < 3)
					c = CHAR_SP;
				else if (k < 5)
					c = CHAR_COLON;
			end
			default: begin
				case (k % 7)
					0: c = CHAR_CR;
					1: c = CHAR_LF;
					2: c = CHAR_COLON;
					3: c = CHAR_SP;
					4: c = CHAR_DOT;
					5: c = CHAR_TAB;
					default: c = CHAR_SLASH;
				endcase
			end
		endcase
		return c;
	endfunction

	// Offers one byte and records its expected result once the transaction completes.
	task automatic push_byte(input byte_row_t row);
		int gap;
		head_res_t r;
		gap = pick_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= row.b;
		new_request <= row.nr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = parse_byte(row.b, row.nr);
		if (row.typed) begin
			r.ev = row.ev;
			r.role = row.role;
			r.err = row.err;
		end
		parse_results_due.push_back(r);
		sent_bytes++;
	endtask

	// Builds one request head with random content, sometimes damaged, and sends it.
	task automatic send_request();
		logic [7:0] req[$];
		byte_row_t row;
		int m;
		int n;
		int i;
		int k;
		if ($urandom_range(0, 15) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) req.push_back(filler(FILL_NAME));
		end else begin
			m = $urandom_range(0, 8);
			for (i = 0; i < VERB_LEN[m]; i++)
				req.push_back(verb_char(m, i));
		end
		req.push_back(CHAR_SP);
		if ($urandom_range(0, 19) != 0)
			req.push_back(CHAR_SLASH);
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 48) : $urandom_range(0, 10);
		repeat (n) req.push_back(filler(FILL_URI));
		req.push_back(CHAR_SP);
		for (i = 0; i < 7; i++)
			req.push_back(VERSION_HEAD[8*(6-i) +: 8]);
		req.push_back(($urandom_range(0, 3) == 0) ? CHAR_ZERO : CHAR_ONE);
		req.push_back(CHAR_CR);
		req.push_back(CHAR_LF);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
		repeat (n) begin
			k = $urandom_range(1, 6);
			repeat (k) req.push_back(filler(FILL_NAME));
			req.push_back(CHAR_COLON);
			k = $urandom_range(0, 2);
			repeat (k) req.push_back($urandom_range(0, 1) ? CHAR_SP : CHAR_TAB);
			k = $urandom_range(0, 8);
			repeat (k) req.push_back(filler(FILL_VALUE));
			req.push_back(CHAR_CR);
			req.push_back(CHAR_LF);
		end
		req.push_back(CHAR_CR);
		req.push_back(CHAR_LF);

		if ($urandom_range(0, 5) == 0) begin
			k = $urandom_range(0, req.size() - 1);
			case ($urandom_range(0, 3))
				0: req[k] = 8'($urandom_range(0, 255));
				1: req[k] = filler(FILL_ODD);
				2: req.insert(k, filler(FILL_ODD));
				default: req.delete(k);
			endcase
		end
		// Trailing bytes land after completion or an error and must be ignored.
		if ($urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 3);
			repeat (n) req.push_back(filler(FILL_ODD));
		end

		for (i = 0; i < req.size(); i++) begin
			row = '{req[i], (i == 0) || ($urandom_range(0, 299) == 0), 1'b0,
				EV_NONE, ROLE_NONE, ERR_NONE};
			push_byte(row);
		end
	endtask

	task automatic settle();
		while (parse_results_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_limits(input logic [15:0] uri_max, input logic [7:0] lines_max,
			input logic [15:0] hdr_max);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_URI;
		cfg_data <= uri_max;
		@(posedge clk);
		cfg_index <= CFG_MAX_HEADER_LINES;
		cfg_data <= {8'h00, lines_max};
		@(posedge clk);
		cfg_index <= CFG_MAX_HEADER_LEN;
		cfg_data <= hdr_max;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_uri = uri_max;
		lim_lines = lines_max;
		lim_hdr = hdr_max;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		head_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (parse_results_due.size() == 0) begin
				$error("result transaction with no byte outstanding");
				fails++;
			end else begin
				want = parse_results_due.pop_front();
				check_field("event_res", 32'(want.ev), 32'(event_res));
				check_field("byte_role", 32'(want.role), 32'(byte_role));
				check_field("method_code", 32'(want.meth), 32'(method_code));
				check_field("version_code", 32'(want.ver), 32'(version_code));
				check_field("uri_length", 32'(want.uri), 32'(uri_length));
				check_field("header_total", 32'(want.hdrs), 32'(header_total));
				check_field("name_length", 32'(want.name_len), 32'(name_length));
				check_field("value_length", 32'(want.value_len), 32'(value_length));
				check_field("error_code", 32'(want.err), 32'(error_code));
			end
		end
	end

	initial begin
		int stall;
		forever begin
			stall = pick_wait(recv_calm);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1)
				@(posedge clk);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int k;
		int lap;
		int target;
		arst_n <= 1'b0;
		clear_parse();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < OPENING_ROWS; k++)
			push_byte(OPENING[k]);

		// The first lap runs on the reset limits.
		for (lap = 0; lap < LAPS; lap++) begin
			if (lap != 0) begin
				in_valid <= 1'b0;
				settle();
				case (lap)
					1: set_limits(16'hFFFF, 8'hFF, 16'hFFFF);
					2: set_limits(16'h0000, 8'h00, 16'h0000);
					3, 6: set_limits(16'($urandom_range(1, 12)), 8'($urandom_range(0, 4)),
						16'($urandom_range(0, 10)));
					4, 7: set_limits(16'($urandom_range(8, 40)), 8'($urandom_range(1, 6)),
						16'($urandom_range(4, 16)));
					default: set_limits(16'($urandom_range(0, 65535)),
						8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
				endcase
			end
			target = sent_bytes + LAP_BYTES;
			while (sent_bytes < target)
				send_request();
		end

		in_valid <= 1'b0;
		settle();
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
